// File: rtl/fir_pkg.sv
// Shared constants, types and the coefficient table of the Q15 FIR filter.
// No dependencies; every other file of the filter but fir_ram takes names from here.
`default_nettype none

package fir_pkg;

    localparam int TAPS    = 19;
    localparam int NCOEF   = 19;
    localparam int SMP_W   = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = SMP_W + COEF_W;
    localparam int FRAC_W  = 15;
    localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W   = PROD_W + TAP_W;
    localparam int HIST_D  = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int HADDR_W = (HIST_D > 1) ? $clog2(HIST_D) : 1;

    typedef logic signed [SMP_W-1:0]  t_sample;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [TAP_W-1:0]         t_tap;
    typedef logic [HADDR_W-1:0]       t_haddr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // Control from the sequencer to the multiply-accumulate datapath.
    typedef struct packed {
        logic acc_clr;
        logic mul_en;
        logic out_load;
        t_tap coef_idx;
    } t_mac_ctl;

    localparam t_coef COEF_TABLE [NCOEF] = '{
        16'sd399,   -16'sd295,  -16'sd944,  -16'sd1554, -16'sd1502,
        -16'sd284,  16'sd2112,  16'sd5061,  16'sd7503,  16'sd8450,
        16'sd7503,  16'sd5061,  16'sd2112,  -16'sd284,  -16'sd1502,
        -16'sd1554, -16'sd944,  -16'sd295,  16'sd399
    };

    // Taps past the end of the table weigh nothing.
    function automatic t_coef fir_coef(input t_tap idx);
        t_coef c;
        c = '0;
        if (int'(idx) < NCOEF) begin
            c = COEF_TABLE[int'(idx)];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/fir_stream_if.sv
// Valid/ready stream interfaces for the filter's sample input and output.
// Payload types come from fir_pkg.
`default_nettype none

interface fir_in_if;
    logic             valid;
    logic             ready;
    fir_pkg::t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fir_out_if;
    logic             valid;
    logic             ready;
    fir_pkg::t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: rtl/fir_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; the width and depth come from its parameters.
`default_nettype none

module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 18
) (
    input  wire                                       i_clk,
    input  wire                                       i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                          i_wdata,
    input  wire                                       i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/fir_mac.sv
// Multiply-accumulate datapath: registered product, wide accumulator,
// Q15 truncation toward zero, saturation and the output sample register. Uses fir_pkg.
`default_nettype none

module fir_mac (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  fir_pkg::t_mac_ctl   i_ctl,
    input  fir_pkg::t_sample    i_operand,
    output fir_pkg::t_sample    o_sample_out
);

    localparam int Q_W = fir_pkg::ACC_W - fir_pkg::FRAC_W;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (fir_pkg::SMP_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(1 << (fir_pkg::SMP_W - 1)));

    logic signed [fir_pkg::PROD_W-1:0] n_prod;
    logic signed [fir_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_vld;
    logic signed [fir_pkg::ACC_W-1:0]  r_acc;
    logic signed [fir_pkg::ACC_W-1:0]  n_biased;
    logic signed [Q_W-1:0]             n_quot;
    logic signed [Q_W-1:0]             n_clamp;
    fir_pkg::t_sample                  r_sample_out;

    always_comb begin
        n_prod = i_operand * fir_pkg::fir_coef(i_ctl.coef_idx);
    end

    // A negative sum is biased by one less than the divisor so that the
    // arithmetic shift truncates toward zero rather than toward minus infinity.
    always_comb begin
        n_biased = r_acc;
        if (r_acc[fir_pkg::ACC_W-1]) begin
            n_biased = r_acc + fir_pkg::ACC_W'((1 << fir_pkg::FRAC_W) - 1);
        end
        n_quot  = n_biased[fir_pkg::ACC_W-1:fir_pkg::FRAC_W];
        n_clamp = n_quot;
        if (n_quot > Q_MAX) begin
            n_clamp = Q_MAX;
        end else if (n_quot < Q_MIN) begin
            n_clamp = Q_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + fir_pkg::ACC_W'(r_prod);
        end
        if (i_ctl.out_load) begin
            r_sample_out <= n_clamp[fir_pkg::SMP_W-1:0];
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

`default_nettype wire

// File: rtl/fir_ctrl.sv
// Sequencer of the filter: handshakes, tap counter, circular addressing of the
// history RAM with per-entry valid bits, and operand selection. Uses fir_pkg.
`default_nettype none

module fir_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  fir_pkg::t_sample    i_sample_in,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output fir_pkg::t_mac_ctl   o_ctl,
    output fir_pkg::t_sample    o_operand,
    output logic                o_ram_we,
    output fir_pkg::t_haddr     o_ram_waddr,
    output fir_pkg::t_sample    o_ram_wdata,
    output logic                o_ram_re,
    output fir_pkg::t_haddr     o_ram_raddr,
    input  fir_pkg::t_sample    i_ram_rdata
);

    localparam fir_pkg::t_tap   LAST_TAP = fir_pkg::TAP_W'(fir_pkg::TAPS - 1);
    localparam fir_pkg::t_haddr LAST_ADR = fir_pkg::HADDR_W'(fir_pkg::HIST_D - 1);

    fir_pkg::t_state  r_state;
    fir_pkg::t_state  n_state;
    fir_pkg::t_tap    r_tap;
    fir_pkg::t_sample r_x;
    fir_pkg::t_haddr  r_head;
    fir_pkg::t_haddr  n_head;
    fir_pkg::t_haddr  r_rd_addr;
    logic [fir_pkg::HIST_D-1:0] r_hvalid;
    logic             r_rd_valid;
    logic             r_out_vld;
    logic             n_accept;
    logic             n_last;

    assign n_last = (r_tap == LAST_TAP);
    assign n_head = (r_head == '0) ? LAST_ADR : r_head - 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fir_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fir_pkg::ST_RUN;
                end
            end
            fir_pkg::ST_RUN: begin
                if (n_last) begin
                    n_state = fir_pkg::ST_DRAIN;
                end
            end
            fir_pkg::ST_DRAIN: begin
                n_state = fir_pkg::ST_FIN;
            end
            fir_pkg::ST_FIN: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = fir_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fir_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_ctl.acc_clr   = 1'b0;
        o_ctl.mul_en    = 1'b0;
        o_ctl.out_load  = 1'b0;
        o_ctl.coef_idx  = r_tap;
        o_ram_we        = 1'b0;
        o_ram_re        = 1'b0;
        unique case (r_state)
            fir_pkg::ST_IDLE: begin
                o_in_ready    = i_rst_n;
                o_ctl.acc_clr = i_in_valid && i_rst_n;
            end
            fir_pkg::ST_RUN: begin
                o_ctl.mul_en = 1'b1;
                o_ram_re     = !n_last;
            end
            fir_pkg::ST_DRAIN: begin
                o_ram_we = (fir_pkg::TAPS > 1);
            end
            fir_pkg::ST_FIN: begin
                o_ctl.out_load = !r_out_vld || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign n_accept    = i_in_valid && o_in_ready;
    assign o_ram_waddr = n_head;
    assign o_ram_wdata = r_x;
    assign o_ram_raddr = r_rd_addr;
    assign o_out_valid = r_out_vld;

    // Tap 0 is the new sample; later taps take the RAM word read the cycle
    // before, or zero where that slot has never been written since reset.
    always_comb begin
        if (r_tap == '0) begin
            o_operand = r_x;
        end else if (r_rd_valid) begin
            o_operand = i_ram_rdata;
        end else begin
            o_operand = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fir_pkg::ST_IDLE;
            r_tap      <= '0;
            r_head     <= '0;
            r_rd_addr  <= '0;
            r_hvalid   <= '0;
            r_rd_valid <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_accept) begin
                r_tap     <= '0;
                r_rd_addr <= r_head;
            end else if (r_state == fir_pkg::ST_RUN && !n_last) begin
                r_tap <= r_tap + 1'b1;
            end
            if (o_ram_re) begin
                r_rd_addr  <= (r_rd_addr == LAST_ADR) ? '0 : r_rd_addr + 1'b1;
                r_rd_valid <= r_hvalid[r_rd_addr];
            end
            if (o_ram_we) begin
                r_head           <= n_head;
                r_hvalid[n_head] <= 1'b1;
            end
            if (o_ctl.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_x <= i_sample_in;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fir_filter_q15_top.sv
// Top level of the 19-tap direct-form Q15 FIR filter.
// Depends on fir_pkg, fir_stream_if, fir_ram, fir_ctrl and fir_mac.
//
//  Channel  Direction  Payload                  Beat taken when
//  i_smp    in         sample_in, 16 b signed   i_smp.valid && i_smp.ready
//  o_smp    out        sample_out, 16 b signed  o_smp.valid && o_smp.ready
//
// Each sample passes through these steps in order: the block takes the beat,
// does one multiply-accumulate per tap through the single multiplier, adds
// the last product, and loads the output register.
// The history RAM gives one word per cycle, which sets the one-tap-per-cycle pace.
// A result waiting in the output register does not hold off the next input
// beat; only loading a new result waits for it to be taken.
// Synchronous reset clears the control state and the history valid bits.
`default_nettype none

module fir_filter_q15_top (
    input  wire     i_clk,
    input  wire     i_rst_n,
    fir_in_if.sink  i_smp,
    fir_out_if.source o_smp
);

    fir_pkg::t_mac_ctl w_ctl;
    fir_pkg::t_sample  w_operand;
    fir_pkg::t_sample  w_sample_out;
    logic              w_out_valid;
    logic              w_in_ready;
    logic              w_ram_we;
    logic              w_ram_re;
    fir_pkg::t_haddr   w_ram_waddr;
    fir_pkg::t_haddr   w_ram_raddr;
    fir_pkg::t_sample  w_ram_wdata;
    fir_pkg::t_sample  w_ram_rdata;

    fir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .i_sample_in (i_smp.sample_in),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_smp.ready),
        .o_ctl       (w_ctl),
        .o_operand   (w_operand),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    fir_ram #(
        .WIDTH (fir_pkg::SMP_W),
        .DEPTH (fir_pkg::HIST_D)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    fir_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_operand    (w_operand),
        .o_sample_out (w_sample_out)
    );

    assign i_smp.ready      = w_in_ready;
    assign o_smp.valid      = w_out_valid;
    assign o_smp.sample_out = w_sample_out;

endmodule

`default_nettype wire

// File: rtl/fir_chk.sv
// Port-level checker for fir_filter_q15_top and the bind that attaches it.
// Depends on fir_pkg and on the top level's interface ports.
`default_nettype none

module fir_chk (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input fir_pkg::t_sample i_out_data
);

    // A result not yet taken must stay put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output beat changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // One sample at a time: the input closes right after a beat ...
    a_busy_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input open during tap sequence");

    // ... and is still closed when the sequence reaches the result load.
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##(fir_pkg::TAPS + 2) !i_in_ready)
        else $error("input reopened before the tap sequence finished");

endmodule

bind fir_filter_q15_top fir_chk u_fir_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_smp.valid),
    .i_out_ready (o_smp.ready),
    .i_out_data  (o_smp.sample_out)
);

`default_nettype wire

// File: tb/sv/fir_filter_q15_top_tb.sv
// Self-checking testbench for fir_filter_q15_top, the 19-tap Q15 FIR filter.
// Needs fir_pkg, the stream interfaces and the filter RTL; it predicts every
// output sample from its own delay line and compares it with the block's.
module fir_filter_q15_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int NUM_WEIGHTS = 19;
    localparam int DRAIN_WAIT  = 30;
    localparam int MAX_REPORTS = 10;

    localparam int TAP_WEIGHTS [NUM_WEIGHTS] = '{
        399, -295, -944, -1554, -1502, -284, 2112, 5061, 7503, 8450,
        7503, 5061, 2112, -284, -1502, -1554, -944, -295, 399
    };

    typedef enum {
        BURST_UNIFORM,
        BURST_EXTREME,
        BURST_PEAK_POS,
        BURST_PEAK_NEG,
        BURST_SMALL,
        BURST_DC
    } t_burst_kind;

    logic i_clk;
    logic i_rst_n;

    fir_in_if  smp_in ();
    fir_out_if smp_out ();

    fir_filter_q15_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_in),
        .o_smp   (smp_out)
    );

    fir_pkg::t_sample dly_line [fir_pkg::TAPS];
    fir_pkg::t_sample want_samples [$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      stall_left = 0;
    bit      idle_en = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none while idling is off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int tap_weight(input int j);
        if (j < NUM_WEIGHTS) return TAP_WEIGHTS[j];
        return 0;
    endfunction

    // Exact sum of products, divided by 2^15 toward zero, then saturated.
    task automatic predict_sample(input fir_pkg::t_sample x);
        longint acc;
        longint q;
        acc = longint'(tap_weight(0)) * longint'(x);
        for (int j = 1; j < fir_pkg::TAPS; j++) begin
            acc += longint'(tap_weight(j)) * longint'(dly_line[j-1]);
        end
        q = acc / 32768;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        want_samples.push_back(fir_pkg::t_sample'(q));
        for (int j = fir_pkg::TAPS - 2; j > 0; j--) begin
            dly_line[j] = dly_line[j-1];
        end
        if (fir_pkg::TAPS > 1) dly_line[0] = x;
    endtask

    task automatic note_failure(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // Sink side: stalls of random length, driven on the falling edge.
    initial begin
        smp_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                smp_out.ready = 1'b0;
                stall_left--;
            end else begin
                smp_out.ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && smp_out.valid && smp_out.ready) begin
            if (want_samples.size() == 0) begin
                note_failure("output beat with nothing pending", 0, smp_out.sample_out);
            end else begin
                fir_pkg::t_sample want;
                want = want_samples.pop_front();
                if (smp_out.sample_out !== want) begin
                    note_failure("sample_out mismatch", want, smp_out.sample_out);
                end
            end
        end
    end

    // Valid stays high into the next beat when no gap is drawn.
    task automatic send_sample(input fir_pkg::t_sample s);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            smp_in.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_in.valid     = 1'b1;
        smp_in.sample_in = s;
        do @(posedge i_clk); while (!smp_in.ready);
        predict_sample(s);
    endtask

    task automatic send_burst(input t_burst_kind kind);
        fir_pkg::t_sample level;
        fir_pkg::t_sample s;
        int      pick;
        level = fir_pkg::t_sample'($urandom());
        for (int k = 0; k < NUM_WEIGHTS; k++) begin
            case (kind) inside
                BURST_UNIFORM: begin
                    s = fir_pkg::t_sample'($urandom());
                end
                BURST_EXTREME: begin
                    pick = $urandom_range(0, 4);
                    case (pick)
                        0: s = 16'sh7fff;
                        1: s = 16'sh8000;
                        2: s = 16'sh0000;
                        3: s = 16'shffff;
                        default: s = 16'sh0001;
                    endcase
                end
                BURST_PEAK_POS, BURST_PEAK_NEG: begin
                    // Full scale with the sign of each weight (opposite for PEAK_NEG), so the sum peaks.
                    if ((tap_weight(NUM_WEIGHTS - 1 - k) >= 0) == (kind == BURST_PEAK_POS)) begin
                        s = 16'sh7fff;
                    end else begin
                        s = 16'sh8000;
                    end
                end
                BURST_SMALL: begin
                    s = fir_pkg::t_sample'($urandom_range(0, 8) - 4);
                end
                default: begin
                    s = level;
                end
            endcase
            send_sample(s);
        end
    endtask

    task automatic test_directed();
        fir_pkg::t_sample tail [6];
        tail = '{16'sh8000, 16'sh7fff, 16'shffff, 16'sh0001, 16'sh8000, 16'sh0000};
        // A full-scale impulse walks through every coefficient in turn.
        send_sample(16'sh7fff);
        repeat (fir_pkg::TAPS - 1) send_sample(16'sh0000);
        foreach (tail[i]) send_sample(tail[i]);
    endtask

    task automatic test_random_stream(input int bursts);
        for (int b = 0; b < bursts; b++) begin
            send_burst(t_burst_kind'($urandom_range(0, 5)));
        end
    endtask

    task automatic test_back_to_back(input int bursts);
        idle_en = 1'b0;
        test_random_stream(bursts);
        idle_en = 1'b1;
    endtask

    task automatic test_stalled_stream(input int bursts);
        test_random_stream(bursts);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        smp_in.valid     = 1'b0;
        smp_in.sample_in = '0;
        foreach (dly_line[i]) dly_line[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_stalled_stream(15);
        test_back_to_back(8);
        test_random_stream(14);

        @(negedge i_clk);
        smp_in.valid = 1'b0;
        while (want_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/fir_pkg.sv
rtl/fir_stream_if.sv
rtl/fir_ram.sv
rtl/fir_mac.sv
rtl/fir_ctrl.sv
rtl/fir_filter_q15_top.sv
rtl/fir_chk.sv
tb/sv/fir_filter_q15_top_tb.sv
